### rtl/core/assert_macros.svh
// Assertion macros shared by the list engine RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BALE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define BALE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BALE_ASSERT(lbl, clk, rstn, prop, msg)
`define BALE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### rtl/core/bale_pkg.sv
// Types and constants for the bounded list engine.
// No dependencies; used by the interfaces, the cell and the top level.
`default_nettype none
package bale_pkg;

    localparam int CAPACITY    = 16;
    localparam int POS_W       = 5;
    localparam int FOUND_W     = 4;
    localparam int COUNT_FLD_W = 5;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [CNT_W-1:0]       CAP_CNT    = CNT_W'(CAPACITY);
    localparam logic [COUNT_FLD_W-1:0] FULL_COUNT = COUNT_FLD_W'(CAPACITY);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOCATE = 2'd2,
        OP_SORTED = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_RANGE     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        t_op                cmd;
        logic signed [31:0] value;
        logic [POS_W-1:0]   position;
    } t_in_item;

    typedef struct packed {
        t_status                status;
        logic [FOUND_W-1:0]     found_index;
        logic [COUNT_FLD_W-1:0] entry_count;
    } t_out_item;

    // Broadcast to every cell for the item being accepted.
    typedef struct packed {
        logic               wr;
        t_op                op;
        logic signed [31:0] value;
        logic [CMP_W-1:0]   position;
        logic [CMP_W-1:0]   count;
    } t_cell_ctl;

endpackage
`default_nettype wire

### rtl/core/bale_in_if.sv
// Command channel of the list engine: valid/ready plus one command item.
// Depends on bale_pkg.
`default_nettype none
interface bale_in_if;
    logic              valid;
    logic              ready;
    bale_pkg::t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface
`default_nettype wire

### rtl/core/bale_out_if.sv
// Result channel of the list engine: valid/ready plus one result item.
// Depends on bale_pkg.
`default_nettype none
interface bale_out_if;
    logic               valid;
    logic               ready;
    bale_pkg::t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface
`default_nettype wire

### rtl/core/bale_cell.sv
// One list slot: holds an entry, shifts from its neighbors, compares for search.
// Depends on bale_pkg.
`default_nettype none
module bale_cell (
    input  wire logic                       i_clk,
    input  wire bale_pkg::t_cell_ctl        i_ctl,
    input  wire logic [bale_pkg::CNT_W-1:0] i_idx,
    input  wire logic signed [31:0]         i_left_data,
    input  wire logic signed [31:0]         i_right_data,
    input  wire logic                       i_suffix_right,
    input  wire logic                       i_suffix_left,
    output logic signed [31:0]              o_data,
    output logic                            o_suffix,
    output logic                            o_match
);
    logic signed [31:0]          r_data;
    logic signed [31:0]          n_data;
    logic [bale_pkg::CMP_W-1:0]  w_idx;
    logic                        w_live;
    logic                        w_gt;

    assign w_idx  = bale_pkg::CMP_W'(i_idx);
    assign w_live = w_idx < i_ctl.count;
    assign w_gt   = r_data > i_ctl.value;
    // true when this slot, if live, and all live slots above it exceed the value
    assign o_suffix = i_suffix_right & (~w_live | w_gt);
    assign o_match  = w_live & (r_data == i_ctl.value);
    assign o_data   = r_data;

    always_comb begin
        n_data = r_data;
        unique case (i_ctl.op)
            bale_pkg::OP_INSERT: begin
                if (w_idx > i_ctl.position) begin
                    n_data = i_left_data;
                end else if (w_idx == i_ctl.position) begin
                    n_data = i_ctl.value;
                end
            end
            bale_pkg::OP_DELETE: begin
                if (w_idx >= i_ctl.position) begin
                    n_data = i_right_data;
                end
            end
            bale_pkg::OP_SORTED: begin
                // slot above the insertion point takes its left neighbor
                if (i_suffix_left) begin
                    n_data = i_left_data;
                end else if (o_suffix) begin
                    n_data = i_ctl.value;
                end
            end
            bale_pkg::OP_LOCATE: begin
                n_data = r_data;
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_data <= n_data;
        end
    end
endmodule
`default_nettype wire

### rtl/core/bounded_array_list_engine.sv
// Top level of the bounded list engine: count, status, result register, cell row.
// Depends on bale_pkg, bale_in_if, bale_out_if, bale_cell, assert_macros.svh.
//
//  port       dir   content                          handshake
//  i_cmd_if   in    cmd, value, position             valid/ready
//  o_res_if   out   status, found_index, entry_count valid/ready
//
// One item per cycle unless stalled; registered result shows in the next cycle.
// All cells shift or compare in the accept cycle; the path is set by the
// slot-wide compare chain and the first-match encoder.
// Synchronous active-low reset empties the list; entries themselves are not cleared.
// A new item is taken while the result register is empty or being drained.
`default_nettype none
`include "assert_macros.svh"
module bounded_array_list_engine (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bale_in_if.sink   i_cmd_if,
    bale_out_if.source o_res_if
);
    localparam int CAP = bale_pkg::CAPACITY;

    logic [bale_pkg::CNT_W-1:0] r_count;
    logic [bale_pkg::CNT_W-1:0] n_count;
    logic                       r_out_valid;
    bale_pkg::t_out_item        r_out;
    bale_pkg::t_out_item        n_out;

    logic                        w_acc;
    logic                        w_full;
    logic                        w_ok;
    logic [bale_pkg::CMP_W-1:0]  w_pos;
    logic [bale_pkg::CMP_W-1:0]  w_cnt;
    logic [bale_pkg::IDX_W-1:0]  w_first;
    logic                        w_any;
    bale_pkg::t_cell_ctl         w_ctl;

    logic signed [31:0] w_data [CAP];
    logic               w_suf  [CAP+1];
    logic               w_match[CAP];

    assign i_cmd_if.ready = ~r_out_valid | o_res_if.ready;
    assign w_acc  = i_cmd_if.valid & i_cmd_if.ready;
    assign w_full = r_count >= bale_pkg::CAP_CNT;
    assign w_pos  = bale_pkg::CMP_W'(i_cmd_if.item.position);
    assign w_cnt  = bale_pkg::CMP_W'(r_count);

    always_comb begin
        w_first = '0;
        w_any   = 1'b0;
        for (int i = CAP - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_first = bale_pkg::IDX_W'(i);
                w_any   = 1'b1;
            end
        end
    end

    always_comb begin
        n_out.status      = bale_pkg::ST_DONE;
        n_out.found_index = '0;
        w_ok              = 1'b0;
        n_count           = r_count;
        unique case (i_cmd_if.item.cmd)
            bale_pkg::OP_INSERT: begin
                if (w_full) begin
                    n_out.status = bale_pkg::ST_FULL;
                end else if (w_pos > w_cnt) begin
                    n_out.status = bale_pkg::ST_RANGE;
                end else begin
                    w_ok    = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            bale_pkg::OP_DELETE: begin
                if (w_pos >= w_cnt) begin
                    n_out.status = bale_pkg::ST_RANGE;
                end else begin
                    w_ok    = 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            bale_pkg::OP_LOCATE: begin
                if (w_any) begin
                    n_out.found_index = bale_pkg::FOUND_W'(w_first);
                end else begin
                    n_out.status = bale_pkg::ST_NOT_FOUND;
                end
            end
            bale_pkg::OP_SORTED: begin
                if (w_full) begin
                    n_out.status = bale_pkg::ST_FULL;
                end else begin
                    w_ok    = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            default: begin
                n_out.status = bale_pkg::ST_DONE;
            end
        endcase
        n_out.entry_count = bale_pkg::COUNT_FLD_W'(n_count);
    end

    assign w_ctl.wr       = w_acc & w_ok;
    assign w_ctl.op       = i_cmd_if.item.cmd;
    assign w_ctl.value    = i_cmd_if.item.value;
    assign w_ctl.position = w_pos;
    assign w_ctl.count    = w_cnt;

    assign w_suf[CAP] = 1'b1;

    for (genvar g = 0; g < CAP; g++) begin : g_cell
        logic signed [31:0] w_left;
        logic signed [31:0] w_right;
        logic               w_suf_left;

        if (g == 0) begin : g_first
            assign w_left     = i_cmd_if.item.value;
            assign w_suf_left = 1'b0;
        end else begin : g_mid
            assign w_left     = w_data[g-1];
            assign w_suf_left = w_suf[g-1];
        end

        if (g == CAP - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_inner
            assign w_right = w_data[g+1];
        end

        bale_cell u_cell (
            .i_clk          (i_clk),
            .i_ctl          (w_ctl),
            .i_idx          (bale_pkg::CNT_W'(g)),
            .i_left_data    (w_left),
            .i_right_data   (w_right),
            .i_suffix_right (w_suf[g+1]),
            .i_suffix_left  (w_suf_left),
            .o_data         (w_data[g]),
            .o_suffix       (w_suf[g]),
            .o_match        (w_match[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_res_if.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out <= n_out;
        end
    end

    assign o_res_if.valid = r_out_valid;
    assign o_res_if.item  = r_out;

    `BALE_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= bale_pkg::CAP_CNT, "count beyond capacity")
    `BALE_ASSERT(a_result_follows, i_clk, i_rst_n, w_acc |=> r_out_valid, "result lost after accept")
    `BALE_ASSERT(a_count_hold, i_clk, i_rst_n, !w_acc |=> $stable(r_count), "count moved without item")
    `BALE_ASSERT(a_full_count, i_clk, i_rst_n, (r_out_valid && r_out.status == bale_pkg::ST_FULL) |-> (r_out.entry_count == bale_pkg::FULL_COUNT), "full status with short list")
endmodule
`default_nettype wire

### sim/bale_list_checker.sv
// Scoreboard for the bounded list engine: watches both channels and predicts each result.
// Depends on bale_pkg, bale_in_if and bale_out_if.
module bale_list_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bale_in_if        i_cmd_if,
    bale_out_if       i_res_if,
    output int        o_fail_count,
    output int        o_pending
);
    import bale_pkg::*;

    logic signed [31:0] list_vals [CAPACITY];
    int                 list_len = 0;
    int                 fail_total = 0;
    t_out_item          expected_results [$];

    // Applies one command to the shadow list and returns the result it should give.
    function automatic t_out_item run_list_cmd(t_in_item c);
        t_out_item          r;
        logic signed [31:0] v;
        int                 pos;
        int                 k;
        r.status      = ST_DONE;
        r.found_index = '0;
        v             = c.value;
        pos           = int'(c.position);
        case (c.cmd)
            OP_INSERT: begin
                if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (pos > list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    for (k = list_len; k > pos; k--)
                        list_vals[k] = list_vals[k-1];
                    list_vals[pos] = v;
                    list_len++;
                end
            end
            OP_DELETE: begin
                if (pos >= list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    for (k = pos; k + 1 < list_len; k++)
                        list_vals[k] = list_vals[k+1];
                    list_len--;
                end
            end
            OP_LOCATE: begin
                r.status = ST_NOT_FOUND;
                for (k = 0; k < list_len; k++) begin
                    if (r.status == ST_NOT_FOUND && list_vals[k] == v) begin
                        r.status      = ST_DONE;
                        r.found_index = FOUND_W'(k);
                    end
                end
            end
            default: begin
                if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    // walk down past every entry strictly greater (signed)
                    k = list_len;
                    while (k > 0 && list_vals[k-1] > v) begin
                        list_vals[k] = list_vals[k-1];
                        k--;
                    end
                    list_vals[k] = v;
                    list_len++;
                end
            end
        endcase
        r.entry_count = COUNT_FLD_W'(list_len);
        return r;
    endfunction

    task automatic report_field(string field, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            list_len = 0;
            expected_results.delete();
        end else begin
            // a result is registered after its item is accepted, so check before queuing the new one
            if (i_res_if.valid && i_res_if.ready) begin
                got = i_res_if.item;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                             $time, got.status, got.found_index, got.entry_count);
                    fail_total++;
                end else begin
                    want = expected_results.pop_front();
                    report_field("status", int'(want.status), int'(got.status));
                    report_field("found_index", int'(want.found_index),
                                 int'(got.found_index));
                    report_field("entry_count", int'(want.entry_count),
                                 int'(got.entry_count));
                end
            end
            if (i_cmd_if.valid && i_cmd_if.ready)
                expected_results.push_back(run_list_cmd(i_cmd_if.item));
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fail_total;
    end

endmodule

### sim/tb_top.sv
// Top of the list engine testbench: clock, reset, command stimulus and result backpressure.
// Depends on bale_pkg, the two channel interfaces, the engine and bale_list_checker.
module tb_top;
    import bale_pkg::*;

    localparam int RANDOM_ITEMS   = 1900;
    localparam int BLOCK_ITEMS    = 50;
    localparam int WATCHDOG_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;
    logic idle_on;
    int   fail_count;
    int   pending;
    int   quiet_cycles;

    bale_in_if  cmd_if ();
    bale_out_if res_if ();

    bounded_array_list_engine uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd_if (cmd_if),
        .o_res_if (res_if)
    );

    bale_list_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_if     (cmd_if),
        .i_res_if     (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Result side backpressure
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (idle_on)
                res_if.ready <= ($urandom_range(99) >= 27);
            else
                res_if.ready <= 1'b1;
        end
    end

    // Ends the run when nothing moves on either channel for too long
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    task automatic send_cmd(t_op op, logic signed [31:0] v, logic [POS_W-1:0] p);
        while (idle_on && $urandom_range(99) < 27) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.item  <= '{cmd: op, value: v, position: p};
        do @(posedge i_clk); while (!cmd_if.ready);
    endtask

    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Often a small window so locates hit, plus extremes; otherwise full-range values
    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = 32'($urandom_range(8)) - 32'd4;
            4: begin
                case ($urandom_range(3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = 32'h0000_0000;
                    default: v = 32'hffff_ffff;
                endcase
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        logic [POS_W-1:0] p;
        case ($urandom_range(19))
            0, 1, 2:  p = POS_W'($urandom_range(31));
            3, 4, 5, 6, 7, 8, 9: p = POS_W'($urandom_range(CAPACITY));
            default:  p = POS_W'($urandom_range(3));
        endcase
        return p;
    endfunction

    // mode 0 grows the list, mode 1 shrinks it, mode 2 is an even mix
    function automatic t_op pick_op(int mode);
        int w;
        w = $urandom_range(99);
        case (mode)
            0: pick_op = (w < 35) ? OP_INSERT : (w < 70) ? OP_SORTED :
                         (w < 80) ? OP_DELETE : OP_LOCATE;
            1: pick_op = (w < 60) ? OP_DELETE : (w < 70) ? OP_INSERT :
                         (w < 80) ? OP_SORTED : OP_LOCATE;
            default: pick_op = t_op'(w % 4);
        endcase
    endfunction

    initial begin : stimulus
        int mode;
        int n;
        i_rst_n      = 1'b0;
        idle_on      = 1'b1;
        cmd_if.valid = 1'b0;
        cmd_if.item  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty list, extremes, equal keys, full list
        send_cmd(OP_DELETE, 32'sd0, 5'd0);
        send_cmd(OP_LOCATE, 32'sd0, 5'd0);
        send_cmd(OP_INSERT, 32'sd7, 5'd1);
        send_cmd(OP_INSERT, 32'h8000_0000, 5'd0);
        send_cmd(OP_INSERT, 32'h7fff_ffff, 5'd1);
        send_cmd(OP_SORTED, -32'sd1, 5'd0);
        send_cmd(OP_SORTED, -32'sd1, 5'd31);
        send_cmd(OP_LOCATE, -32'sd1, 5'd0);
        send_cmd(OP_DELETE, 32'sd0, 5'd4);
        send_cmd(OP_DELETE, 32'sd0, 5'd31);
        repeat (11) send_cmd(OP_SORTED, pick_value(), 5'd0);
        send_cmd(OP_INSERT, 32'sd12345, 5'd15);
        send_cmd(OP_INSERT, 32'sd1, 5'd0);
        send_cmd(OP_SORTED, 32'sd1, 5'd0);
        send_cmd(OP_LOCATE, 32'sd12345, 5'd0);
        send_cmd(OP_DELETE, 32'sd0, 5'd15);

        mode = 0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % BLOCK_ITEMS == 0)
                mode = $urandom_range(2);
            if (n == 700)
                idle_on <= 1'b0;
            if (n == 1100)
                idle_on <= 1'b1;
            if (n == 400 || n == 1500)
                wait_drained();
            send_cmd(pick_op(mode), pick_value(), pick_position());
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/bale_pkg.sv
rtl/core/bale_in_if.sv
rtl/core/bale_out_if.sv
rtl/core/bale_cell.sv
rtl/core/bounded_array_list_engine.sv
sim/bale_list_checker.sv
sim/tb_top.sv
